>>> design/dlf_pkg.sv
// shared types, codes and reset values of the delimited line framer
`default_nettype none

package dlf_pkg;

   // width of max_length and of the length counters (counters carry one more bit)
   localparam int LENGTH_WIDTH_DEFAULT = 12;

   // configuration port
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_INDEX_WIDTH = 3;

   typedef enum logic [REG_INDEX_WIDTH-1:0] {
      REG_START_BYTE    = 3'd0,
      REG_START_ENABLE  = 3'd1,
      REG_END_BYTE      = 3'd2,
      REG_SKIP_BYTE     = 3'd3,
      REG_SKIP_ENABLE   = 3'd4,
      REG_MAX_LENGTH    = 3'd5,
      REG_TIMEOUT_TICKS = 3'd6
   } reg_index_type;

   // register reset values
   localparam logic [7:0]  START_BYTE_RESET    = 8'd36;
   localparam logic        START_ENABLE_RESET  = 1'b1;
   localparam logic [7:0]  END_BYTE_RESET      = 8'd10;
   localparam logic [7:0]  SKIP_BYTE_RESET     = 8'd13;
   localparam logic        SKIP_ENABLE_RESET   = 1'b1;
   localparam logic [31:0] MAX_LENGTH_RESET    = 32'd1000;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

   localparam int TIMER_WIDTH = 16;

   // input word codes
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // result word codes
   typedef enum logic [1:0] {
      KIND_BYTE     = 2'd0,
      KIND_END      = 2'd1,
      KIND_OVERFLOW = 2'd2,
      KIND_TIMEOUT  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] line_byte;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

>>> design/delimited_line_framer.sv
// delimited line framer: per-byte line framing with apb-style control registers
// a result word is registered in the head register (or the skid register while the head waits) before it shows on rsp_
// throughput: one input word per cycle while req_ready is high, set by the per-word state update
// a two-entry result buffer keeps req_ready high while one result waits downstream
// reset (synchronous, active high) loads register defaults, returns to hunting,
// clears all counters and empties the result buffer
`default_nettype none

module delimited_line_framer #(
   parameter int LENGTH_WIDTH = dlf_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // input words
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire                                 req_func,
   input  wire  [7:0]                          req_rx_byte,
   // result words
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [1:0]                          rsp_kind,
   output logic [7:0]                          rsp_line_byte,
   output logic                                rsp_last,
   // configuration
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [dlf_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire  [dlf_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [dlf_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int CountWidth = LENGTH_WIDTH + 1;
   localparam int TW = dlf_pkg::TIMER_WIDTH;
   localparam int DW = dlf_pkg::CSR_DATA_WIDTH;
   localparam logic [LENGTH_WIDTH-1:0] MaxLengthReset =
      dlf_pkg::MAX_LENGTH_RESET[LENGTH_WIDTH-1:0];
   localparam logic [CountWidth-1:0] CountOne = {{(CountWidth-1){1'b0}}, 1'b1};
   localparam logic [TW-1:0] TimerOne = {{(TW-1){1'b0}}, 1'b1};

   // configuration registers
   logic [7:0]              start_byte_ff;
   logic                    start_enable_ff;
   logic [7:0]              end_byte_ff;
   logic [7:0]              skip_byte_ff;
   logic                    skip_enable_ff;
   logic [LENGTH_WIDTH-1:0] max_length_ff;
   logic [TW-1:0]           timeout_ticks_ff;

   // framer state
   logic                  in_line_ff, in_line_in;
   logic [CountWidth-1:0] raw_count_ff, raw_count_in;
   logic [CountWidth-1:0] line_length_ff, line_length_in;
   logic [TW-1:0]         idle_timer_ff, idle_timer_in;

   // result buffer: head register and skid register
   logic                 head_valid_ff, head_valid_in;
   dlf_pkg::result_type  head_ff, head_in;
   logic                 skid_valid_ff, skid_valid_in;
   dlf_pkg::result_type  skid_ff, skid_in;

   logic                    accept;
   logic                    pop;
   logic                    res_valid;
   dlf_pkg::result_type     res;
   logic                    csr_write;
   logic [dlf_pkg::REG_INDEX_WIDTH-1:0] csr_index;
   logic [CountWidth-1:0]   max_ext;
   logic [CountWidth-1:0]   raw_eff;
   logic [CountWidth-1:0]   len_eff;
   logic [CountWidth-1:0]   raw_plus;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[dlf_pkg::CSR_ADDR_WIDTH-1:2];

   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;
   assign pop       = head_valid_ff & rsp_ready;

   assign rsp_valid     = head_valid_ff;
   assign rsp_kind      = head_ff.kind;
   assign rsp_line_byte = head_ff.line_byte;
   assign rsp_last      = head_ff.last;

   assign max_ext = {1'b0, max_length_ff};

   // register read
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         dlf_pkg::REG_START_BYTE:    csr_prdata = {{(DW-8){1'b0}}, start_byte_ff};
         dlf_pkg::REG_START_ENABLE:  csr_prdata = {{(DW-1){1'b0}}, start_enable_ff};
         dlf_pkg::REG_END_BYTE:      csr_prdata = {{(DW-8){1'b0}}, end_byte_ff};
         dlf_pkg::REG_SKIP_BYTE:     csr_prdata = {{(DW-8){1'b0}}, skip_byte_ff};
         dlf_pkg::REG_SKIP_ENABLE:   csr_prdata = {{(DW-1){1'b0}}, skip_enable_ff};
         dlf_pkg::REG_MAX_LENGTH:
            csr_prdata = {{(DW-LENGTH_WIDTH){1'b0}}, max_length_ff};
         dlf_pkg::REG_TIMEOUT_TICKS: csr_prdata = {{(DW-TW){1'b0}}, timeout_ticks_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   // per-word framing step
   always_comb begin
      in_line_in     = in_line_ff;
      raw_count_in   = raw_count_ff;
      line_length_in = line_length_ff;
      idle_timer_in  = idle_timer_ff;
      res_valid      = 1'b0;
      res.kind       = dlf_pkg::KIND_BYTE;
      res.line_byte  = 8'd0;
      res.last       = 1'b0;
      raw_eff        = in_line_ff ? raw_count_ff : '0;
      len_eff        = in_line_ff ? line_length_ff : '0;
      raw_plus       = '0;

      if (accept) begin
         if (req_func == dlf_pkg::FUNC_TICK) begin
            if (in_line_ff && (idle_timer_ff != '0)) begin
               idle_timer_in = idle_timer_ff - TimerOne;
               if (idle_timer_ff == TimerOne) begin
                  in_line_in     = 1'b0;
                  raw_count_in   = '0;
                  line_length_in = '0;
                  idle_timer_in  = '0;
                  res_valid      = 1'b1;
                  res.kind       = dlf_pkg::KIND_TIMEOUT;
                  res.last       = 1'b1;
               end
            end
         end else if (!in_line_ff && start_enable_ff) begin
            // hunting for the start byte, everything else is noise
            if (req_rx_byte == start_byte_ff) begin
               in_line_in     = 1'b1;
               raw_count_in   = '0;
               line_length_in = '0;
               idle_timer_in  = timeout_ticks_ff;
            end else begin
               raw_plus = raw_count_ff + CountOne;
               if (raw_plus > max_ext) begin
                  raw_count_in = '0;
                  res_valid    = 1'b1;
                  res.kind     = dlf_pkg::KIND_OVERFLOW;
               end else begin
                  raw_count_in = raw_plus;
               end
            end
         end else begin
            // inside a line, or a line opened by this very byte
            in_line_in    = 1'b1;
            idle_timer_in = timeout_ticks_ff;
            raw_plus      = raw_eff + CountOne;
            if (req_rx_byte == end_byte_ff) begin
               in_line_in     = 1'b0;
               raw_count_in   = '0;
               line_length_in = '0;
               idle_timer_in  = '0;
               res_valid      = 1'b1;
               res.kind       = (len_eff > max_ext) ? dlf_pkg::KIND_OVERFLOW
                                                    : dlf_pkg::KIND_END;
               res.last       = 1'b1;
            end else if (raw_plus > max_ext) begin
               in_line_in     = 1'b0;
               raw_count_in   = '0;
               line_length_in = '0;
               idle_timer_in  = '0;
               res_valid      = 1'b1;
               res.kind       = dlf_pkg::KIND_OVERFLOW;
               res.last       = 1'b1;
            end else begin
               raw_count_in   = raw_plus;
               line_length_in = len_eff;
               if (!(skip_enable_ff && (req_rx_byte == skip_byte_ff))) begin
                  line_length_in = len_eff + CountOne;
                  res_valid      = 1'b1;
                  res.line_byte  = req_rx_byte;
               end
            end
         end
      end
   end

   // two-entry result buffer; a push never meets a full skid register
   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = res_valid;
            head_in       = res;
         end
      end else if (res_valid) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff    <= dlf_pkg::START_BYTE_RESET;
         start_enable_ff  <= dlf_pkg::START_ENABLE_RESET;
         end_byte_ff      <= dlf_pkg::END_BYTE_RESET;
         skip_byte_ff     <= dlf_pkg::SKIP_BYTE_RESET;
         skip_enable_ff   <= dlf_pkg::SKIP_ENABLE_RESET;
         max_length_ff    <= MaxLengthReset;
         timeout_ticks_ff <= dlf_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            dlf_pkg::REG_START_BYTE:    start_byte_ff    <= csr_pwdata[7:0];
            dlf_pkg::REG_START_ENABLE:  start_enable_ff  <= csr_pwdata[0];
            dlf_pkg::REG_END_BYTE:      end_byte_ff      <= csr_pwdata[7:0];
            dlf_pkg::REG_SKIP_BYTE:     skip_byte_ff     <= csr_pwdata[7:0];
            dlf_pkg::REG_SKIP_ENABLE:   skip_enable_ff   <= csr_pwdata[0];
            dlf_pkg::REG_MAX_LENGTH:    max_length_ff    <= csr_pwdata[LENGTH_WIDTH-1:0];
            dlf_pkg::REG_TIMEOUT_TICKS: timeout_ticks_ff <= csr_pwdata[TW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_line_ff     <= 1'b0;
         raw_count_ff   <= '0;
         line_length_ff <= '0;
         idle_timer_ff  <= '0;
         head_valid_ff  <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         in_line_ff     <= in_line_in;
         raw_count_ff   <= raw_count_in;
         line_length_ff <= line_length_in;
         idle_timer_ff  <= idle_timer_in;
         head_valid_ff  <= head_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire
